FILE: hdl/gdf_pkg.sv
// ----------------------------------------------------------------------------
// gdf_pkg: shared types and constants of the dual gyro arbiter and fuser
// Sample width, derived widths, register indexes, reset values and the
// word types that pass between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package gdf_pkg;

  localparam int SAMPLE_BITS = 20;
  localparam int AXES        = 3;

  // abs difference of two samples needs one more bit than a sample
  localparam int ADIFF_W = SAMPLE_BITS + 1;
  localparam int SQ_W    = 2 * SAMPLE_BITS;
  // sum of three squares
  localparam int NORM_W  = SQ_W + 2;

  localparam int CNT_W   = 8;
  localparam int THR_W   = 20;
  localparam int LIMSQ_W = 40;

  localparam int DIF_CMP_W  = (ADIFF_W > THR_W) ? ADIFF_W : THR_W;
  localparam int NORM_CMP_W = (NORM_W > LIMSQ_W) ? NORM_W : LIMSQ_W;

  localparam int CFG_DATA_W = LIMSQ_W;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIVERGE_LIMIT   = 2'd0,
    CFG_DIFF_THRESHOLD  = 2'd1,
    CFG_EXPLOSION_LIMIT = 2'd2
  } gdf_cfg_idx_e;

  localparam logic [CNT_W-1:0]   DIVERGE_LIMIT_RST = CNT_W'(5);
  localparam logic [THR_W-1:0]   DIFF_THRESH_RST   = THR_W'(2048);
  // 35 rad/s squared in Q.24
  localparam logic [LIMSQ_W-1:0] EXPLODE_LIM_RST   = LIMSQ_W'(64'd20552089600);

  localparam logic [CNT_W-1:0]   CNT_MAX = '1;

  typedef logic [AXES-1:0][SAMPLE_BITS-1:0] gdf_vec_t;

  typedef struct packed {
    logic [CNT_W-1:0]   diverge_limit;
    logic [THR_W-1:0]   diff_threshold;
    logic [LIMSQ_W-1:0] explosion_limit_sq;
  } gdf_cfg_t;

  // word handed from the compare/square stage to the vote stage
  typedef struct packed {
    logic                      diverge;
    logic [AXES-1:0][SQ_W-1:0] prim_sq;
    gdf_vec_t                  prim;
    gdf_vec_t                  sec;
    gdf_vec_t                  avg;
  } gdf_mid_t;

endpackage

`default_nettype wire

FILE: hdl/gdf_front.sv
// ----------------------------------------------------------------------------
// gdf_front: axis compare and square stage
// Finds the largest axis difference against the threshold, squares the
// primary axes and forms the floor average, then registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gdf_front
  import gdf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     en_i,
  input  wire gdf_vec_t prim_i,
  input  wire gdf_vec_t sec_i,
  input  wire gdf_cfg_t cfg_i,
  output gdf_mid_t      mid_q
);

  logic signed [SAMPLE_BITS:0]   diff [AXES];
  logic        [ADIFF_W-1:0]     adiff [AXES];
  logic signed [SQ_W-1:0]        pext [AXES];
  logic signed [SAMPLE_BITS:0]   sum  [AXES];
  logic        [ADIFF_W-1:0]     max01;
  logic        [ADIFF_W-1:0]     max_all;
  gdf_mid_t                      mid_d;

  always_comb begin
    mid_d = '0;
    for (int a = 0; a < AXES; a++) begin
      diff[a]  = (SAMPLE_BITS+1)'($signed(prim_i[a])) - (SAMPLE_BITS+1)'($signed(sec_i[a]));
      adiff[a] = diff[a][SAMPLE_BITS] ? ADIFF_W'(-diff[a]) : ADIFF_W'(diff[a]);
      pext[a]  = SQ_W'($signed(prim_i[a]));
      mid_d.prim_sq[a] = SQ_W'(pext[a] * pext[a]);
      sum[a]   = (SAMPLE_BITS+1)'($signed(prim_i[a])) + (SAMPLE_BITS+1)'($signed(sec_i[a]));
      // drop the low bit: floor of half the sum
      mid_d.avg[a] = sum[a][SAMPLE_BITS:1];
    end
    max01   = (adiff[0] > adiff[1]) ? adiff[0] : adiff[1];
    max_all = (max01 > adiff[2]) ? max01 : adiff[2];
    mid_d.diverge = DIF_CMP_W'(max_all) > DIF_CMP_W'(cfg_i.diff_threshold);
    mid_d.prim = prim_i;
    mid_d.sec  = sec_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gdf_vote.sv
// ----------------------------------------------------------------------------
// gdf_vote: divergence counter, fault decision and fusion select
// Holds the count and both suspect flags and registers the fused word.
// ----------------------------------------------------------------------------
`default_nettype none

module gdf_vote
  import gdf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire gdf_mid_t mid_i,
  input  wire gdf_cfg_t cfg_i,
  output gdf_vec_t      fused_q,
  output logic          pbad_q,
  output logic          sbad_q
);

  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic              ps_q, ps_d, ss_q, ss_d;
  logic [NORM_W-1:0] norm;
  gdf_vec_t          fused_d;

  always_comb begin
    cnt_d   = cnt_q;
    ps_d    = ps_q;
    ss_d    = ss_q;
    cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
    norm    = NORM_W'(mid_i.prim_sq[0]) + NORM_W'(mid_i.prim_sq[1])
            + NORM_W'(mid_i.prim_sq[2]);
    if (mid_i.diverge) begin
      if (cnt_inc >= cfg_i.diverge_limit) begin
        // decide: blame the primary only if its norm blew up
        if (NORM_CMP_W'(norm) > NORM_CMP_W'(cfg_i.explosion_limit_sq)) begin
          ps_d = 1'b1;
          ss_d = 1'b0;
        end else begin
          ps_d = 1'b0;
          ss_d = 1'b1;
        end
        cnt_d = cfg_i.diverge_limit;
      end else begin
        cnt_d = cnt_inc;
      end
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      ps_d = 1'b0;
      ss_d = 1'b0;
    end

    case ({ps_d, ss_d})
      2'b10:   fused_d = mid_i.sec;
      2'b01:   fused_d = mid_i.prim;
      default: fused_d = mid_i.avg;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ps_q  <= 1'b0;
      ss_q  <= 1'b0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
      ps_q  <= ps_d;
      ss_q  <= ss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fused_q <= fused_d;
      pbad_q  <= ps_d;
      sbad_q  <= ss_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dual_gyro_arbiter_fuser.sv
// ----------------------------------------------------------------------------
// dual_gyro_arbiter_fuser: voter and fuser for two redundant rate sensors
// Input register, compare/square stage, vote stage and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one word per frame carries a primary and a secondary
//   three-axis sample (signed Q7.12), taken when in_valid_i is high and
//   in_stall_o is low. Output channel: one word per input word with the
//   fused sample and both fault flags, taken when out_valid_o is high and
//   out_stall_i is low.
//   From the accepting edge on, a word passes the input register, the
//   compare/square register and the result register, whose load raises
//   out_valid_o. Throughput is one word per cycle while out_stall_i is
//   low; the divergence counter and suspect flags update once per word in
//   the vote stage, and each stage holds one multiplier per axis at most.
//   Configuration: write a register index and data on cfg_*; cfg_ready_o is
//   always high. Write only while the block is idle.
//   Reset: the pipeline empties, counter and flags clear, registers take
//   their defaults (limit 5, threshold 0.5 rad/s, explosion 35^2).
//   Receiver stall: the result word holds; up to three words fill the
//   pipeline before in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_gyro_arbiter_fuser
  import gdf_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] prim_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] prim_y_i,
  input  wire logic signed [SAMPLE_BITS-1:0] prim_z_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sec_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sec_y_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sec_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      fused_x_o,
  output logic signed [SAMPLE_BITS-1:0]      fused_y_o,
  output logic signed [SAMPLE_BITS-1:0]      fused_z_o,
  output logic                               primary_bad_o,
  output logic                               secondary_bad_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i
);

  gdf_cfg_t cfg_q;
  logic     v_in_q, v_mid_q, v_out_q;
  logic     adv_in, adv_mid, adv_out;
  gdf_vec_t prim_q, sec_q;
  gdf_mid_t mid_q;
  gdf_vec_t fused_q;

  // configuration registers; no side effects, so always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.diverge_limit      <= DIVERGE_LIMIT_RST;
      cfg_q.diff_threshold     <= DIFF_THRESH_RST;
      cfg_q.explosion_limit_sq <= EXPLODE_LIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DIVERGE_LIMIT:   cfg_q.diverge_limit      <= cfg_data_i[CNT_W-1:0];
        CFG_DIFF_THRESHOLD:  cfg_q.diff_threshold     <= cfg_data_i[THR_W-1:0];
        CFG_EXPLOSION_LIMIT: cfg_q.explosion_limit_sq <= cfg_data_i[LIMSQ_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // each stage advances when it is empty or the next one advances
  assign adv_out    = !v_out_q || !out_stall_i;
  assign adv_mid    = !v_mid_q || adv_out;
  assign adv_in     = !v_in_q || adv_mid;
  assign in_stall_o = !adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q  <= 1'b0;
      v_mid_q <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      if (adv_in) begin
        v_in_q <= in_valid_i;
      end
      if (adv_mid) begin
        v_mid_q <= v_in_q;
      end
      if (adv_out) begin
        v_out_q <= v_mid_q;
      end
    end
  end

  // capture the sample pair
  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv_in) begin
      prim_q <= {prim_z_i, prim_y_i, prim_x_i};
      sec_q  <= {sec_z_i, sec_y_i, sec_x_i};
    end
  end

  gdf_front u_front (
    .clk_i  (clk_i),
    .en_i   (v_in_q && adv_mid),
    .prim_i (prim_q),
    .sec_i  (sec_q),
    .cfg_i  (cfg_q),
    .mid_q  (mid_q)
  );

  // state advances exactly once per word leaving the middle stage
  gdf_vote u_vote (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (v_mid_q && adv_out),
    .mid_i   (mid_q),
    .cfg_i   (cfg_q),
    .fused_q (fused_q),
    .pbad_q  (primary_bad_o),
    .sbad_q  (secondary_bad_o)
  );

  assign out_valid_o = v_out_q;
  assign fused_x_o   = $signed(fused_q[0]);
  assign fused_y_o   = $signed(fused_q[1]);
  assign fused_z_o   = $signed(fused_q[2]);

endmodule

`default_nettype wire

FILE: hdl/gdf_checker.sv
// ----------------------------------------------------------------------------
// gdf_checker: port-level checks of the dual gyro arbiter and fuser
// Watches the handshakes and fault flags; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gdf_checker
  import gdf_pkg::*;
(
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic signed [SAMPLE_BITS-1:0] fused_x_o,
  input wire logic                          primary_bad_o,
  input wire logic                          secondary_bad_o
);

  // a stalled result word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped under stall");

  // a stalled result word keeps its x sample and primary fault flag
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(fused_x_o) && $stable(primary_bad_o))
    else $error("result word changed under stall");

  // the decision never blames both sensors
  a_one_suspect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(primary_bad_o && secondary_bad_o))
    else $error("both sensors flagged");

  // with no result waiting the pipeline always has room
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

endmodule

bind dual_gyro_arbiter_fuser gdf_checker u_gdf_checker (.*);

`default_nettype wire
